[hdl/pcmm_pkg.sv]
// Shared types, constants and helpers of the per-channel masked mean block.
package pcmm_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_SET_DEF  = 65536;

    localparam int ACC_W  = 64;
    localparam int CNT_W  = 17;
    localparam int DVD_W  = 96;
    localparam int DVS_W  = 64;
    localparam int STEP_W = 7;
    localparam int CIN_W  = 7;

    localparam logic [1:0] MODE_ARITH = 2'd0;
    localparam logic [1:0] MODE_RMS   = 2'd1;
    localparam logic [1:0] MODE_HARM  = 2'd2;

    localparam logic       REG_MODE     = 1'b0;
    localparam logic       REG_CHANNELS = 1'b1;

    localparam logic [CIN_W-1:0] CIN_RESET = 7'd16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_REC,
        S_ORD,
        S_OCALC,
        S_DIV,
        S_SQ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] cnt;
        logic             zero;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    function automatic logic [31:0] sat32(input logic neg, input logic [DVD_W-1:0] mag);
        logic [31:0] res;
        if (neg) begin
            if (mag > DVD_W'(32'h8000_0000)) res = 32'h8000_0000;
            else res = ~mag[31:0] + 32'd1;
        end else begin
            if (mag > DVD_W'(32'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
            else res = mag[31:0];
        end
        return res;
    endfunction

endpackage

[hdl/pcmm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module pcmm_div
    import pcmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (fits) r_rem <= DVS_W'(trial - {1'b0, r_dvs});
            else r_rem <= trial[DVS_W-1:0];
            r_q <= {r_q[DVD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[hdl/pcmm_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module pcmm_isqrt
    import pcmm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

[hdl/per_channel_masked_mean.sv]
// Top level of the per-channel masked mean block: channel store, sequencer and arithmetic units.
//
// Each accepted request is taken in, then its channel entry is read, modified and written back
// in the single-port store; a non-zero value in harmonic mode first has its Q1.32 reciprocal
// computed through the shared serial divider. After the request marked last, one result per
// channel in use follows; most results come from the one-bit-per-cycle divider, and RMS results
// from 96 divider steps plus 32 square-root steps through the divider and root units; no request
// is taken until the last result has been delivered. Channel entries carry valid bits, so the
// store needs no clearing pass.
module per_channel_masked_mean
    import pcmm_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int MAX_SET_SIZE = MAX_SET_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [5:0]         i_channel,
    input  logic signed [15:0] i_sample_value,
    input  logic               i_value_missing,
    input  logic               i_last_of_set,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_result_channel,
    output logic signed [31:0] o_mean_value,
    output logic [1:0]         o_status,
    output logic               o_last_result,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CIN_W-1:0] CH_MAX  = CIN_W'(CHANNELS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SET_SIZE);

    t_state             r_state, n_state;
    logic [1:0]         r_mode;
    logic [CIN_W-1:0]   r_cin;
    logic [5:0]         r_ch;
    logic signed [15:0] r_val;
    logic               r_miss;
    logic               r_last;
    logic [CIN_W-1:0]   r_k, n_k;
    logic [CHANNELS-1:0] r_vld;
    t_entry             mem [CHANNELS];
    t_entry             r_rd;
    logic               r_rd_vld;
    logic               r_neg, n_neg;
    logic [5:0]         r_o_ch;
    logic [31:0]        r_o_mean;
    t_status            r_o_st;
    logic               r_o_last;

    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic               mem_we;
    t_entry             wdata;
    logic               clear_vld;
    logic               ld_out;
    logic [31:0]        n_mean;
    t_status            n_st;
    t_div_req           div_req;
    logic               div_done;
    logic [DVD_W-1:0]   quot;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        root;

    t_entry             e;
    logic [1:0]         mode_e;
    logic [CIN_W-1:0]   n_eff;
    logic               take;
    logic signed [16:0] vx;
    logic [16:0]        vmag;
    logic signed [31:0] vsq;
    logic [ACC_W-1:0]   acc_mag;
    logic [ACC_W-1:0]   rec;

    assign e      = r_rd_vld ? r_rd : '0;
    assign mode_e = (r_mode == MODE_RMS || r_mode == MODE_HARM) ? r_mode : MODE_ARITH;
    assign n_eff  = (r_cin == '0) ? CIN_W'(1) : ((r_cin > CH_MAX) ? CH_MAX : r_cin);
    assign take   = !r_miss && ({1'b0, r_ch} < n_eff) && (e.cnt < MAX_CNT);
    assign vx     = 17'(r_val);
    assign vmag   = vx[16] ? 17'(-vx) : 17'(vx);
    assign vsq    = r_val * r_val;
    assign acc_mag = e.acc[ACC_W-1] ? ACC_W'(-e.acc) : e.acc;
    assign rec    = r_val[15] ? ACC_W'(-{31'b0, quot[32:0]}) : {31'b0, quot[32:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ARITH;
            r_cin  <= CIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:     r_mode <= i_cfg_data[1:0];
                REG_CHANNELS: r_cin  <= i_cfg_data;
                default:      r_mode <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (clear_vld) r_vld <= '0;
            else if (mem_we) r_vld[r_ch[CW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_ch[CW-1:0]] <= wdata;
        if (rd_en) begin
            r_rd     <= mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_ch   <= i_channel;
            r_val  <= i_sample_value;
            r_miss <= i_value_missing;
            r_last <= i_last_of_set;
        end
        r_neg <= n_neg;
        if (ld_out) begin
            r_o_ch   <= r_k[5:0];
            r_o_mean <= n_mean;
            r_o_st   <= n_st;
            r_o_last <= (r_k + CIN_W'(1)) == n_eff;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_neg     = r_neg;
        rd_en     = 1'b0;
        rd_addr   = r_k[CW-1:0];
        mem_we    = 1'b0;
        wdata     = e;
        clear_vld = 1'b0;
        ld_out    = 1'b0;
        n_mean    = '0;
        n_st      = ST_OK;
        div_req   = '0;
        sq_start  = 1'b0;
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                rd_addr = i_channel[CW-1:0];
                if (i_valid) begin
                    rd_en   = 1'b1;
                    n_k     = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = r_last ? S_ORD : S_IDLE;
                if (take) begin
                    wdata.cnt = e.cnt + CNT_W'(1);
                    if (mode_e == MODE_HARM && r_val != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b1, {(DVD_W-1){1'b0}}};
                        div_req.divisor  = DVS_W'(vmag);
                        div_req.steps    = STEP_W'(33);
                        n_state          = S_REC;
                    end else begin
                        mem_we = 1'b1;
                        if (mode_e == MODE_HARM) wdata.zero = 1'b1;
                        else if (mode_e == MODE_RMS) wdata.acc = e.acc + {32'b0, vsq};
                        else wdata.acc = e.acc + ACC_W'(r_val);
                    end
                end
            end
            S_REC: begin
                if (div_done) begin
                    mem_we    = 1'b1;
                    wdata.cnt = e.cnt + CNT_W'(1);
                    wdata.acc = e.acc + rec;
                    n_state   = r_last ? S_ORD : S_IDLE;
                end
            end
            S_ORD: begin
                rd_en   = 1'b1;
                n_state = S_OCALC;
            end
            S_OCALC: begin
                n_neg = e.acc[ACC_W-1];
                if (e.cnt == '0) begin
                    ld_out  = 1'b1;
                    n_st    = ST_EMPTY;
                    n_state = S_OUT;
                end else if (mode_e == MODE_HARM && e.zero) begin
                    ld_out  = 1'b1;
                    n_st    = ST_ZERO;
                    n_state = S_OUT;
                end else if (mode_e == MODE_HARM && acc_mag == '0) begin
                    ld_out  = 1'b1;
                    n_mean  = 32'h7FFF_FFFF;
                    n_state = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                    if (mode_e == MODE_RMS) begin
                        div_req.dividend = {e.acc, 32'b0};
                        div_req.divisor  = DVS_W'(e.cnt);
                        div_req.steps    = STEP_W'(96);
                    end else if (mode_e == MODE_HARM) begin
                        div_req.dividend = {1'b0, e.cnt, 78'b0};
                        div_req.divisor  = acc_mag;
                        div_req.steps    = STEP_W'(66);
                    end else begin
                        div_req.dividend = {acc_mag[47:0], 48'b0};
                        div_req.divisor  = DVS_W'(e.cnt);
                        div_req.steps    = STEP_W'(64);
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (mode_e == MODE_RMS) begin
                        sq_start = 1'b1;
                        n_state  = S_SQ;
                    end else begin
                        ld_out  = 1'b1;
                        n_mean  = sat32(r_neg, quot);
                        n_state = S_OUT;
                    end
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    ld_out  = 1'b1;
                    n_mean  = root[31] ? 32'h7FFF_FFFF : root;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_o_last) begin
                        clear_vld = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + CIN_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    pcmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    pcmm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (quot[63:0]),
        .o_done  (sq_done),
        .o_root  (root)
    );

    assign o_result_channel = r_o_ch;
    assign o_mean_value     = r_o_mean;
    assign o_status         = r_o_st;
    assign o_last_result    = r_o_last;

`ifndef SYNTHESIS
    a_chan_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_result_channel} < n_eff))
        else $error("result channel beyond channels in use");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_mean_value == '0)
        else $error("error status carries a non-zero mean");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_result |=> r_vld == '0)
        else $error("store not cleared after last result");

    a_rms_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK && mode_e == MODE_RMS |-> !o_mean_value[31])
        else $error("negative RMS mean");
`endif

endmodule

[tb/per_channel_masked_mean_tb.sv]
// Self-checking testbench of the per-channel masked mean block with its own mean predictor.
module per_channel_masked_mean_tb
    import pcmm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH        = 16;
    localparam int SET_LIMIT  = 65536;
    localparam int QUIET_MAX  = 4000;
    localparam int SETTLE     = 250;

    typedef struct {
        logic [5:0]  ch;
        logic [31:0] mean;
        t_status     st;
        logic        last;
    } t_mean_exp;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [5:0]         i_channel;
    logic signed [15:0] i_sample_value;
    logic               i_value_missing;
    logic               i_last_of_set;
    logic               o_valid;
    logic               i_stall;
    logic [5:0]         o_result_channel;
    logic signed [31:0] o_mean_value;
    logic [1:0]         o_status;
    logic               o_last_result;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [6:0]         i_cfg_data;

    per_channel_masked_mean dut (.*);

    longint      acc_sum [NCH];
    int unsigned val_cnt [NCH];
    bit          zero_hit[NCH];
    logic [1:0]  cur_mode;
    logic [6:0]  cur_chans;

    t_mean_exp   means_due[$];
    int          errors;
    bit          tx_idle;
    bit          rx_idle;
    int          rx_hold;
    int          quiet;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint sat_q16(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic bit [63:0] root64(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint harm_mean(longint rsum, int unsigned cnt);
        bit        neg;
        bit [63:0] d;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] lim;
        int        i;
        neg = rsum < 0;
        d = neg ? -rsum : rsum;
        lim = 64'd1 << 31;
        if (d == 0) return 64'sd2147483647;
        q = (64'(cnt) << 16) / d;
        r = (64'(cnt) << 16) % d;
        for (i = 0; i < 32 && q <= lim; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= d) begin
                r -= d;
                q |= 1;
            end
        end
        if (q > lim) q = lim + 1;
        return sat_q16(neg ? -longint'(q) : longint'(q));
    endfunction

    function automatic int unsigned chans_eff();
        if (cur_chans == 0) return 1;
        if (cur_chans > NCH) return NCH;
        return cur_chans;
    endfunction

    function automatic void clear_stores();
        for (int k = 0; k < NCH; k++) begin
            acc_sum[k] = 0;
            val_cnt[k] = 0;
            zero_hit[k] = 0;
        end
    endfunction

    function automatic void predict_means(logic [5:0] ch, logic signed [15:0] v, logic miss,
                                          logic last);
        int unsigned n;
        logic [1:0]  md;
        longint      sv;
        longint      mag;
        longint      m;
        bit [63:0]   q;
        t_mean_exp   e;
        n = chans_eff();
        md = (cur_mode == 2'd3) ? MODE_ARITH : cur_mode;
        sv = v;
        if (!miss && ch < n && val_cnt[ch] < SET_LIMIT) begin
            val_cnt[ch]++;
            if (md == MODE_RMS) begin
                acc_sum[ch] += sv * sv;
            end else if (md == MODE_HARM) begin
                if (sv == 0) begin
                    zero_hit[ch] = 1;
                end else begin
                    mag = sv < 0 ? -sv : sv;
                    m = longint'((64'd1 << 32) / 64'(mag));
                    acc_sum[ch] += sv < 0 ? -m : m;
                end
            end else begin
                acc_sum[ch] += sv;
            end
        end
        if (!last) return;
        for (int k = 0; k < n; k++) begin
            m = 0;
            e.st = ST_OK;
            if (val_cnt[k] == 0) begin
                e.st = ST_EMPTY;
            end else if (md == MODE_HARM && zero_hit[k]) begin
                e.st = ST_ZERO;
            end else if (md == MODE_RMS) begin
                q = (64'(acc_sum[k]) / val_cnt[k]) << 32;
                q += ((64'(acc_sum[k]) % val_cnt[k]) << 32) / val_cnt[k];
                m = sat_q16(longint'(root64(q)));
            end else if (md == MODE_HARM) begin
                m = harm_mean(acc_sum[k], val_cnt[k]);
            end else begin
                mag = acc_sum[k] < 0 ? -acc_sum[k] : acc_sum[k];
                q = (64'(mag) << 16) / val_cnt[k];
                m = sat_q16(acc_sum[k] < 0 ? -longint'(q) : longint'(q));
            end
            e.ch = 6'(k);
            e.mean = m[31:0];
            e.last = (k + 1 == n);
            means_due.push_back(e);
        end
        clear_stores();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_value(logic [5:0] ch, logic signed [15:0] v, logic miss, logic last);
        bit taken;
        int gap;
        i_valid <= 1'b1;
        i_channel <= ch;
        i_sample_value <= v;
        i_value_missing <= miss;
        i_last_of_set <= last;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        predict_means(ch, v, miss, last);
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (means_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODE) cur_mode = data[1:0];
        else cur_chans = data;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_arith_extremes();
        write_reg(REG_MODE, 7'(MODE_ARITH));
        write_reg(REG_CHANNELS, 7'd4);
        send_value(6'd0, 16'sh7FFF, 0, 0);
        send_value(6'd0, 16'sh7FFF, 0, 0);
        send_value(6'd1, 16'sh8000, 0, 0);
        send_value(6'd1, 16'sh0003, 1, 0);
        send_value(6'd2, -16'sd7, 0, 0);
        send_value(6'd2, 16'sd2, 0, 0);
        send_value(6'd5, 16'sd100, 0, 0);
        send_value(6'd63, 16'sd9, 0, 1);
        drain();
    endtask

    task automatic test_rms_wide_channels();
        write_reg(REG_MODE, 7'(MODE_RMS));
        write_reg(REG_CHANNELS, 7'd64);
        send_value(6'd0, 16'sh8000, 0, 0);
        send_value(6'd3, -16'sd5, 0, 0);
        send_value(6'd3, 16'sd12, 0, 0);
        send_value(6'd15, 16'sd1, 0, 1);
        drain();
    endtask

    task automatic test_harmonic_cases();
        write_reg(REG_MODE, 7'(MODE_HARM));
        write_reg(REG_CHANNELS, 7'd3);
        send_value(6'd0, 16'sd1, 0, 0);
        send_value(6'd0, -16'sd1, 0, 0);
        send_value(6'd1, 16'sd0, 0, 0);
        send_value(6'd1, 16'sd5, 0, 0);
        send_value(6'd2, -16'sd3, 0, 0);
        send_value(6'd2, 16'sd7, 1, 1);
        drain();
    endtask

    task automatic test_mode_three_and_mode_switch();
        write_reg(REG_MODE, 7'd3);
        write_reg(REG_CHANNELS, 7'd0);
        send_value(6'd0, -16'sd9, 0, 0);
        send_value(6'd0, 16'sd4, 0, 1);
        drain();
        write_reg(REG_CHANNELS, 7'd2);
        write_reg(REG_MODE, 7'(MODE_ARITH));
        send_value(6'd0, 16'sd10, 0, 0);
        drain();
        write_reg(REG_MODE, 7'(MODE_HARM));
        send_value(6'd0, 16'sd4, 0, 0);
        send_value(6'd1, 16'sd2, 0, 1);
        drain();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_MODE, 7'(MODE_ARITH));
        write_reg(REG_CHANNELS, 7'd16);
        rx_hold = 600;
        tx_idle = 0;
        for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < 6; k++) send_value(6'($urandom_range(0, 15)), pick_value(), 0, 0);
            send_value(6'd0, pick_value(), 0, 1);
        end
        tx_idle = 1;
        drain();
    endtask

    task automatic test_random_sets();
        int len;
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_MODE, 7'($urandom_range(0, 3)));
            case ($urandom_range(0, 5))
                0: write_reg(REG_CHANNELS, 7'($urandom_range(64, 127)));
                1: write_reg(REG_CHANNELS, 7'd0);
                default: write_reg(REG_CHANNELS, 7'($urandom_range(1, 16)));
            endcase
            rx_idle = (p % 3 != 2);
            tx_idle = (p % 4 != 3);
            for (int s = 0; s < 5; s++) begin
                len = $urandom_range(0, 18);
                for (int k = 0; k < len; k++) begin
                    send_value($urandom_range(0, 9) == 0 ? 6'($urandom) :
                               6'($urandom_range(0, chans_eff() - 1)),
                               pick_value(), $urandom_range(0, 6) == 0, 0);
                end
                send_value(6'($urandom), pick_value(), 1'($urandom_range(0, 1)), 1);
            end
            drain();
        end
        rx_idle = 1;
        tx_idle = 1;
    endtask

    initial begin
        errors = 0;
        tx_idle = 1;
        rx_idle = 1;
        rx_hold = 0;
        cur_mode = MODE_ARITH;
        cur_chans = CIN_RESET;
        clear_stores();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_channel <= '0;
        i_sample_value <= '0;
        i_value_missing <= 1'b0;
        i_last_of_set <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_MODE;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arith_extremes();
        test_rms_wide_channels();
        test_harmonic_cases();
        test_mode_three_and_mode_switch();
        test_output_backpressure();
        test_random_sets();
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int        n;
        bit        got;
        t_mean_exp seen;
        t_mean_exp e;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            n = rx_idle ? $urandom_range(0, 15) : 0;
            if (rx_hold > 0) begin
                n = rx_hold;
                rx_hold = 0;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got = o_valid;
                seen.ch = o_result_channel;
                seen.mean = o_mean_value;
                seen.st = t_status'(o_status);
                seen.last = o_last_result;
                @(posedge i_clk);
            end while (!got);
            if (means_due.size() == 0) begin
                report_mismatch("unexpected result, channel", seen.ch, 0);
            end else begin
                e = means_due.pop_front();
                if (seen.ch !== e.ch) report_mismatch("result_channel", seen.ch, e.ch);
                if (seen.mean !== e.mean) report_mismatch("mean_value", seen.mean, e.mean);
                if (seen.st !== e.st) report_mismatch("status", seen.st, e.st);
                if (seen.last !== e.last) report_mismatch("last_result", seen.last, e.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_MAX) begin
                $display("ERROR %0t: no progress, %0d results outstanding", $realtime,
                         means_due.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end
endmodule

[filelist.f]
hdl/pcmm_pkg.sv
hdl/pcmm_div.sv
hdl/pcmm_isqrt.sv
hdl/per_channel_masked_mean.sv
tb/per_channel_masked_mean_tb.sv
